@@ hw/rtl/kvts_pkg.sv @@
// Shared types, constants and character-class helpers for the keyword/value scanner.
// Used by keyword_value_token_scanner_unit and its checker; no dependencies.
`timescale 1ns / 1ps

package kvts_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned AddrW     = 48;
    localparam int unsigned CntW      = 16;   // gap/value counter width, saturating
    localparam int unsigned ProgW     = 3;
    localparam int unsigned KwLen     = 4;
    localparam int unsigned NumKw     = 2;
    localparam int unsigned OutDataW  = AddrW + 2 * CntW;
    localparam int unsigned CfgDataW  = 64;
    localparam int unsigned CfgAddrW  = 4;

    // Register index, taken from paddr[3] (registers sit 8 bytes apart)
    localparam logic RegMinLen = 1'b0;
    localparam logic RegBase   = 1'b1;

    localparam logic [ByteW-1:0] ChNul   = 8'h00;
    localparam logic [ByteW-1:0] ChTab   = 8'h09;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChCr    = 8'h0D;
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChUnder = 8'h5F;
    localparam logic [ProgW-1:0] ProgDone = ProgW'(KwLen);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GAP,
        PH_VALUE
    } phase_t;

    function automatic logic is_blank(input logic [ByteW-1:0] c);
        return (c == ChSpace) || (c == ChTab);
    endfunction

    function automatic logic is_graph(input logic [ByteW-1:0] c);
        return (c >= 8'h21) && (c <= 8'h7E);
    endfunction

    function automatic logic is_word(input logic [ByteW-1:0] c);
        return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z")) ||
               ((c >= "A") && (c <= "Z")) || (c == ChUnder);
    endfunction

    function automatic logic is_end(input logic [ByteW-1:0] c);
        return is_blank(c) || (c == ChCr) || (c == ChLf) || (c == ChNul);
    endfunction

    function automatic logic [ByteW-1:0] to_lower(input logic [ByteW-1:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
    endfunction

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == {CntW{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Keyword 0 is "user", keyword 1 is "pass"
    function automatic logic [ByteW-1:0] kw_char(input logic kw, input logic [1:0] idx);
        logic [ByteW-1:0] ch;
        case ({kw, idx})
            3'b000:  ch = "u";
            3'b001:  ch = "s";
            3'b010:  ch = "e";
            3'b011:  ch = "r";
            3'b100:  ch = "p";
            3'b101:  ch = "a";
            3'b110:  ch = "s";
            default: ch = "s";
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/keyword_value_token_scanner_unit.sv @@
// Top level of the keyword/value scanner: input byte register logic, per-keyword
// trackers, result register and APB register file. Depends on kvts_pkg.
`timescale 1ns / 1ps

// Scans one byte per clock cycle for the keywords "user" and "pass" (any case),
// each tracked on its own, and reports a match when the value after the keyword's
// blank gap is terminated, or at the byte marked tlast. A byte is taken in every
// cycle while the single result register is empty or being drained this cycle;
// the result of a byte is shown in the cycle after that byte's transaction. The
// rate is set by the result register: a stalled m_tready holds s_tready low
// only while a result is waiting. m_tdata carries the match address (offset of
// the keyword's first byte plus base_address), gap and value lengths; m_tuser
// carries the keyword id. Registers: min_value_length at 0x0, base_address at 0x8.
module keyword_value_token_scanner_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // slave stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kvts_pkg::ByteW-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,
    // master stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kvts_pkg::OutDataW-1:0]    m_tdata,   // [47:0] match_address,
                                                        // [63:48] gap_length,
                                                        // [79:64] value_length
    output logic [0:0]                       m_tuser,   // [0] keyword_id
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [kvts_pkg::CfgAddrW-1:0]    paddr,
    input  logic [kvts_pkg::CfgDataW-1:0]    pwdata,
    output logic [kvts_pkg::CfgDataW-1:0]    prdata,
    output logic                             pready
);
    import kvts_pkg::*;

    logic [ByteW-1:0] min_len_reg;
    logic [AddrW-1:0] base_reg;
    logic [AddrW-1:0] offset_reg,  offset_next;
    logic [ByteW-1:0] prev_reg,    prev_next;
    logic [ProgW-1:0] prog_reg     [NumKw];
    logic [ProgW-1:0] prog_next    [NumKw];
    logic [ProgW-1:0] prog_mid     [NumKw];
    phase_t           phase_reg    [NumKw];
    phase_t           phase_next   [NumKw];
    logic [AddrW-1:0] start_reg    [NumKw];
    logic [AddrW-1:0] start_next   [NumKw];
    logic [CntW-1:0]  gap_reg      [NumKw];
    logic [CntW-1:0]  gap_next     [NumKw];
    logic [CntW-1:0]  val_reg      [NumKw];
    logic [CntW-1:0]  val_next     [NumKw];
    logic [NumKw-1:0] emit_main;
    logic [NumKw-1:0] emit_last;

    logic             out_valid_reg, out_valid_next;
    logic             out_id_reg;
    logic [AddrW-1:0] out_addr_reg;
    logic [CntW-1:0]  out_gap_reg;
    logic [CntW-1:0]  out_val_reg;

    logic             accept;
    logic             cfg_we;
    logic [ByteW-1:0] lc;
    logic [CntW-1:0]  min_ext;
    logic             any_emit;
    logic             sel;

    assign accept  = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[3] == RegBase) ? CfgDataW'(base_reg) : CfgDataW'(min_len_reg);
    assign lc      = to_lower(s_tdata);
    assign min_ext = CntW'(min_len_reg);

    always_comb begin
        for (int k = 0; k < NumKw; k++) begin
            phase_next[k] = phase_reg[k];
            gap_next[k]   = gap_reg[k];
            val_next[k]   = val_reg[k];
            start_next[k] = start_reg[k];
            emit_main[k]  = 1'b0;

            // advance the gap/value candidate
            unique case (phase_reg[k])
                PH_GAP: begin
                    if (is_blank(s_tdata)) begin
                        gap_next[k] = sat_inc(gap_reg[k]);
                    end else if (is_graph(s_tdata)) begin
                        phase_next[k] = PH_VALUE;
                        val_next[k]   = CntW'(1);
                    end else begin
                        phase_next[k] = PH_IDLE;
                    end
                end
                PH_VALUE: begin
                    if (is_graph(s_tdata)) begin
                        val_next[k] = sat_inc(val_reg[k]);
                    end else begin
                        phase_next[k] = PH_IDLE;
                        emit_main[k]  = is_end(s_tdata) && (val_reg[k] > min_ext);
                    end
                end
                default: phase_next[k] = PH_IDLE;
            endcase

            // a completed keyword opens a gap on a blank
            prog_mid[k] = prog_reg[k];
            if (prog_reg[k] == ProgDone) begin
                if (is_blank(s_tdata) && phase_next[k] == PH_IDLE) begin
                    phase_next[k] = PH_GAP;
                    gap_next[k]   = CntW'(1);
                    val_next[k]   = '0;
                    start_next[k] = offset_reg - AddrW'(KwLen);
                end
                prog_mid[k] = '0;
            end

            if (prog_mid[k] != '0 && lc == kw_char(k[0], prog_mid[k][1:0])) begin
                prog_next[k] = prog_mid[k] + 1'b1;
            end else if (lc == kw_char(k[0], 2'd0) && !is_word(prev_reg)) begin
                prog_next[k] = ProgDone - ProgW'(KwLen - 1);
            end else begin
                prog_next[k] = '0;
            end

            // end of region acts as a NUL terminator
            emit_last[k] = s_tlast && (phase_next[k] == PH_VALUE) && (val_next[k] > min_ext);
        end

        offset_next = offset_reg + 1'b1;
        prev_next   = s_tdata;

        // user keyword wins a tie
        any_emit = |emit_main || |emit_last;
        if (emit_main[0]) begin
            sel = 1'b0;
        end else if (emit_main[1]) begin
            sel = 1'b1;
        end else begin
            sel = !emit_last[0];
        end

        out_valid_next = out_valid_reg && !m_tready;
        if (accept && any_emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_len_reg   <= 8'd4;
            base_reg      <= '0;
            offset_reg    <= '0;
            prev_reg      <= ChNul;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NumKw; k++) begin
                prog_reg[k]  <= '0;
                phase_reg[k] <= PH_IDLE;
                start_reg[k] <= '0;
                gap_reg[k]   <= '0;
                val_reg[k]   <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                if (paddr[3] == RegBase) begin
                    base_reg <= pwdata[AddrW-1:0];
                end else begin
                    min_len_reg <= pwdata[ByteW-1:0];
                end
            end
            if (accept) begin
                if (s_tlast) begin
                    // start a fresh region
                    offset_reg <= '0;
                    prev_reg   <= ChNul;
                    for (int k = 0; k < NumKw; k++) begin
                        prog_reg[k]  <= '0;
                        phase_reg[k] <= PH_IDLE;
                        start_reg[k] <= '0;
                        gap_reg[k]   <= '0;
                        val_reg[k]   <= '0;
                    end
                end else begin
                    offset_reg <= offset_next;
                    prev_reg   <= prev_next;
                    for (int k = 0; k < NumKw; k++) begin
                        prog_reg[k]  <= prog_next[k];
                        phase_reg[k] <= phase_next[k];
                        start_reg[k] <= start_next[k];
                        gap_reg[k]   <= gap_next[k];
                        val_reg[k]   <= val_next[k];
                    end
                end
            end
        end
        if (accept && any_emit) begin
            out_id_reg   <= sel;
            out_addr_reg <= base_reg + start_reg[sel];
            // a terminated value keeps its counts even if a new gap opens on this byte
            out_gap_reg  <= (|emit_main) ? gap_reg[sel] : gap_next[sel];
            out_val_reg  <= (|emit_main) ? val_reg[sel] : val_next[sel];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_val_reg, out_gap_reg, out_addr_reg};
    assign m_tuser  = out_id_reg;

endmodule

@@ hw/rtl/kvts_checker.sv @@
// Port-level checker for keyword_value_token_scanner_unit, attached by bind.
// Depends on kvts_pkg for field widths.
`timescale 1ns / 1ps

module kvts_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kvts_pkg::OutDataW-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);
    import kvts_pkg::*;

    // a waiting result holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reported lengths are never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[AddrW+CntW-1:AddrW] != '0) &&
                     (m_tdata[OutDataW-1:AddrW+CntW] != '0))
        else $error("zero gap or value length reported");

    // an empty result register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

    // reset drops any pending result
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind keyword_value_token_scanner_unit kvts_checker u_kvts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
